/* rtl/tnrd_pkg.sv */
// Shared types, byte codes and helper functions for the telnet receive deframer.
// No dependencies; the parser, result register, top level, checker and bench import this package.
package tnrd_pkg;

    localparam logic [7:0] BYTE_IAC  = 8'd255;
    localparam logic [7:0] BYTE_DONT = 8'd254;
    localparam logic [7:0] BYTE_DO   = 8'd253;
    localparam logic [7:0] BYTE_WONT = 8'd252;
    localparam logic [7:0] BYTE_WILL = 8'd251;
    localparam logic [7:0] BYTE_SB   = 8'd250;
    localparam logic [7:0] BYTE_SE   = 8'd240;
    localparam logic [7:0] BYTE_EOR  = 8'd239;

    localparam logic [7:0] OPT_BINARY   = 8'd0;
    localparam logic [7:0] OPT_TERMTYPE = 8'd24;
    localparam logic [7:0] OPT_EOR      = 8'd25;
    localparam logic [7:0] OPT_NEWENV   = 8'd39;

    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_EOR    = 3'd1,
        KIND_REPLY  = 3'd2,
        KIND_SUB    = 3'd3,
        KIND_SUBEND = 3'd4
    } kind_t;

    // All results caused by one input byte share one kind.
    typedef struct packed {
        kind_t                           kind;
        logic [1:0]                      count;
        logic [MAX_RESULTS-1:0][7:0]     value;
    } result_t;

    function automatic logic option_supported(input logic [7:0] opt);
        return (opt == OPT_BINARY) || (opt == OPT_TERMTYPE) ||
               (opt == OPT_EOR) || (opt == OPT_NEWENV);
    endfunction

endpackage

/* rtl/tnrd_in_if.sv */
// Input channel of the telnet receive deframer: one received byte per transaction.
// Standalone interface; no package needed.
interface tnrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/tnrd_out_if.sv */
// Result channel of the telnet receive deframer: kind, value and last per transaction.
// Standalone interface; no package needed.
interface tnrd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

/* rtl/tnrd_parser.sv */
// Telnet command parser: holds the parse state and decodes one byte into its results.
// Depends on tnrd_pkg.
module tnrd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        rx_byte,
    output tnrd_pkg::result_t result
);
    import tnrd_pkg::*;

    typedef enum logic [2:0] {
        ST_DATA   = 3'd0,
        ST_IAC    = 3'd1,
        ST_VERB   = 3'd2,
        ST_SB     = 3'd3,
        ST_SB_IAC = 3'd4
    } state_t;

    typedef enum logic [1:0] {
        VERB_WILL = 2'd0,
        VERB_WONT = 2'd1,
        VERB_DO   = 2'd2,
        VERB_DONT = 2'd3
    } verb_t;

    state_t state_reg, state_next;
    verb_t  verb_reg, verb_next;
    logic   open_reg, open_next;
    logic   supported;

    assign supported = option_supported(rx_byte);

    always_comb
    begin
        state_next   = state_reg;
        verb_next    = verb_reg;
        open_next    = open_reg;
        result       = '0;
        result.kind  = KIND_DATA;
        result.count = 2'd0;
        unique case (state_reg)
            ST_IAC:
            begin
                if (rx_byte == BYTE_IAC)
                begin
                    state_next      = ST_DATA;
                    open_next       = 1'b1;
                    result.count    = 2'd1;
                    result.value[0] = BYTE_IAC;
                end
                else if (rx_byte == BYTE_WILL || rx_byte == BYTE_WONT ||
                         rx_byte == BYTE_DO || rx_byte == BYTE_DONT)
                begin
                    state_next = ST_VERB;
                    priority if (rx_byte == BYTE_WILL)
                        verb_next = VERB_WILL;
                    else if (rx_byte == BYTE_WONT)
                        verb_next = VERB_WONT;
                    else if (rx_byte == BYTE_DO)
                        verb_next = VERB_DO;
                    else
                        verb_next = VERB_DONT;
                end
                else if (rx_byte == BYTE_SB)
                begin
                    state_next = ST_SB;
                end
                else
                begin
                    // Unknown commands are dropped; EOR only closes an open record.
                    state_next = ST_DATA;
                    if (rx_byte == BYTE_EOR && open_reg)
                    begin
                        open_next    = 1'b0;
                        result.kind  = KIND_EOR;
                        result.count = 2'd1;
                    end
                end
            end
            ST_VERB:
            begin
                state_next = ST_DATA;
                if (verb_reg == VERB_DO || verb_reg == VERB_WILL)
                begin
                    result.kind     = KIND_REPLY;
                    result.count    = 2'd3;
                    result.value[0] = BYTE_IAC;
                    result.value[2] = rx_byte;
                    if (verb_reg == VERB_DO)
                        result.value[1] = supported ? BYTE_WILL : BYTE_WONT;
                    else
                        result.value[1] = supported ? BYTE_DO : BYTE_DONT;
                end
            end
            ST_SB:
            begin
                if (rx_byte == BYTE_IAC)
                begin
                    state_next = ST_SB_IAC;
                end
                else
                begin
                    result.kind     = KIND_SUB;
                    result.count    = 2'd1;
                    result.value[0] = rx_byte;
                end
            end
            ST_SB_IAC:
            begin
                if (rx_byte == BYTE_IAC)
                begin
                    state_next      = ST_SB;
                    result.kind     = KIND_SUB;
                    result.count    = 2'd1;
                    result.value[0] = BYTE_IAC;
                end
                else if (rx_byte == BYTE_SE)
                begin
                    state_next   = ST_DATA;
                    result.kind  = KIND_SUBEND;
                    result.count = 2'd1;
                end
                else
                begin
                    state_next = ST_SB;
                end
            end
            default:
            begin
                // Plain data, and any unused state code, behaves as plain data.
                if (rx_byte == BYTE_IAC)
                begin
                    state_next = ST_IAC;
                end
                else
                begin
                    state_next      = ST_DATA;
                    open_next       = 1'b1;
                    result.count    = 2'd1;
                    result.value[0] = rx_byte;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DATA;
            verb_reg  <= VERB_WILL;
            open_reg  <= 1'b0;
        end
        else if (take)
        begin
            state_reg <= state_next;
            verb_reg  <= verb_next;
            open_reg  <= open_next;
        end
    end

endmodule

/* rtl/tnrd_out_buf.sv */
// Result register: holds the results of one byte and hands them out one per transaction.
// Depends on tnrd_pkg and tnrd_out_if.
module tnrd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tnrd_pkg::result_t result,
    output logic              free,
    tnrd_out_if.source        res
);
    import tnrd_pkg::*;

    result_t    result_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       at_last;
    logic       drain;

    assign at_last = (idx_reg == (result_reg.count - 2'd1));
    assign drain   = res.ready && at_last;
    // A new byte may enter while the final pending result leaves.
    assign free    = !valid_reg || drain;

    assign res.valid = valid_reg;
    assign res.kind  = result_reg.kind;
    assign res.value = result_reg.value[idx_reg];
    assign res.last  = at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load && result.count != 2'd0)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (valid_reg && res.ready)
        begin
            if (at_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && result.count != 2'd0)
            result_reg <= result;
    end

endmodule

/* rtl/telnet_receive_deframer.sv */
// Telnet receive deframer top level: parser followed by a result register.
// The first result of a byte is registered and presented in the cycle after its transaction.
// Throughput: one single-result byte per cycle when not stalled; a reply is three results.
// Input readiness follows the result register: it frees when its final result is taken.
// Reset (asynchronous, active low) returns to plain data with no record open and no result.
module telnet_receive_deframer (
    input  logic        clk,
    input  logic        rst_n,
    tnrd_in_if.sink     rx,
    tnrd_out_if.source  res
);
    import tnrd_pkg::*;

    result_t result;
    logic    free;
    logic    take;

    assign rx.ready = free;
    assign take     = rx.valid && free;

    tnrd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx.rx_byte),
        .result  (result)
    );

    tnrd_out_buf u_out_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (take),
        .result (result),
        .free   (free),
        .res    (res)
    );

endmodule

/* rtl/tnrd_checker.sv */
// Port-level checks for the telnet receive deframer, bound to the top level.
// Depends on tnrd_pkg for the result kind codes.
module tnrd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_kind,
    input logic [7:0] out_value,
    input logic       out_last
);
    import tnrd_pkg::*;

    // A stalled result holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value))
        else $error("result changed while stalled");

    // The bytes of a reply follow each other with no gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_kind == KIND_REPLY && !out_last
        |=> out_valid && out_kind == KIND_REPLY)
        else $error("reply sequence broken");

    // Marker results carry a zero value and close their byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_EOR || out_kind == KIND_SUBEND)
        |-> out_value == 8'd0 && out_last)
        else $error("marker result malformed");

    // Data and subnegotiation bytes come one per input byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_DATA || out_kind == KIND_SUB) |-> out_last)
        else $error("data result not final");

endmodule

bind telnet_receive_deframer tnrd_checker u_tnrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_kind  (res.kind),
    .out_value (res.value),
    .out_last  (res.last)
);

/* sim/telnet_receive_deframer_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the telnet receive deframer: a byte stream in, typed results out.
// Depends on tnrd_pkg, the tnrd_in_if and tnrd_out_if interfaces and the deframer top level.
module telnet_receive_deframer_tb;
    import tnrd_pkg::*;

    typedef enum logic [2:0] {
        PS_DATA,
        PS_IAC,
        PS_VERB,
        PS_SB,
        PS_SB_IAC
    } parse_state_t;

    typedef enum logic [1:0] {
        VERB_WILL,
        VERB_WONT,
        VERB_DO,
        VERB_DONT
    } verb_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } deframed_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tnrd_in_if  rx_ch ();
    tnrd_out_if res_ch ();

    telnet_receive_deframer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    logic [7:0] rx_backlog[$];
    deframed_t  due_results[$];
    int         bytes_queued = 0;
    int         bytes_taken = 0;
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       byte_fired = 1'b0;

    // Shadow parser state.
    parse_state_t parse_st = PS_DATA;
    verb_t        verb_held = VERB_WILL;
    logic         record_open = 1'b0;

    logic [7:0] known_opts[4] = '{OPT_BINARY, OPT_TERMTYPE, OPT_EOR, OPT_NEWENV};
    logic [7:0] verb_bytes[4] = '{BYTE_WILL, BYTE_WONT, BYTE_DO, BYTE_DONT};
    int         phase_send_idle[4] = '{0, 87, 0, 11};
    int         phase_recv_stall[4] = '{0, 0, 87, 11};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void expect_result(input kind_t k, input logic [7:0] v, input logic l);
        deframed_t r;
        r.kind = k;
        r.value = v;
        r.last = l;
        due_results.push_back(r);
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        logic       opt_known;
        logic [7:0] answer;
        opt_known = (b == OPT_BINARY) || (b == OPT_TERMTYPE) ||
                    (b == OPT_EOR) || (b == OPT_NEWENV);
        case (parse_st)
            PS_IAC:
            begin
                if (b == BYTE_IAC)
                begin
                    parse_st = PS_DATA;
                    record_open = 1'b1;
                    expect_result(KIND_DATA, BYTE_IAC, 1'b1);
                end
                else if (b == BYTE_WILL || b == BYTE_WONT || b == BYTE_DO || b == BYTE_DONT)
                begin
                    verb_held = (b == BYTE_WILL) ? VERB_WILL :
                                (b == BYTE_WONT) ? VERB_WONT :
                                (b == BYTE_DO)   ? VERB_DO : VERB_DONT;
                    parse_st = PS_VERB;
                end
                else if (b == BYTE_SB)
                begin
                    parse_st = PS_SB;
                end
                else
                begin
                    // Unknown commands fall back to data; EOR only counts with a record open.
                    parse_st = PS_DATA;
                    if (b == BYTE_EOR && record_open)
                    begin
                        record_open = 1'b0;
                        expect_result(KIND_EOR, 8'd0, 1'b1);
                    end
                end
            end
            PS_VERB:
            begin
                parse_st = PS_DATA;
                if (verb_held == VERB_DO || verb_held == VERB_WILL)
                begin
                    if (verb_held == VERB_DO)
                        answer = opt_known ? BYTE_WILL : BYTE_WONT;
                    else
                        answer = opt_known ? BYTE_DO : BYTE_DONT;
                    expect_result(KIND_REPLY, BYTE_IAC, 1'b0);
                    expect_result(KIND_REPLY, answer, 1'b0);
                    expect_result(KIND_REPLY, b, 1'b1);
                end
            end
            PS_SB:
            begin
                if (b == BYTE_IAC)
                    parse_st = PS_SB_IAC;
                else
                    expect_result(KIND_SUB, b, 1'b1);
            end
            PS_SB_IAC:
            begin
                if (b == BYTE_IAC)
                begin
                    parse_st = PS_SB;
                    expect_result(KIND_SUB, BYTE_IAC, 1'b1);
                end
                else if (b == BYTE_SE)
                begin
                    parse_st = PS_DATA;
                    expect_result(KIND_SUBEND, 8'd0, 1'b1);
                end
                else
                begin
                    parse_st = PS_SB;
                end
            end
            default:
            begin
                if (b == BYTE_IAC)
                begin
                    parse_st = PS_IAC;
                end
                else
                begin
                    parse_st = PS_DATA;
                    record_open = 1'b1;
                    expect_result(KIND_DATA, b, 1'b1);
                end
            end
        endcase
    endfunction

    // Monitor: predicts on each input transaction and checks each result transaction.
    always @(posedge clk)
    begin
        deframed_t want;
        if (rst_n)
        begin
            byte_fired = rx_ch.valid && rx_ch.ready;
            if (byte_fired)
            begin
                parse_byte(rx_ch.rx_byte);
                bytes_taken++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d value %02h last %0b",
                                 res_ch.kind, res_ch.value, res_ch.last);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (res_ch.kind !== want.kind || res_ch.value !== want.value ||
                        res_ch.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: got kind %0d value %02h last %0b, ",
                                      "expected kind %0d value %02h last %0b"},
                                     res_ch.kind, res_ch.value, res_ch.last,
                                     want.kind, want.value, want.last);
                    end
                end
            end
        end
    end

    // Driver: feeds the byte backlog and toggles result readiness.
    always @(negedge clk)
    begin
        logic       next_valid;
        logic [7:0] next_byte;
        if (!rst_n)
        begin
            rx_ch.valid <= 1'b0;
            rx_ch.rx_byte <= 8'd0;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            next_valid = rx_ch.valid && !byte_fired;
            next_byte = rx_ch.rx_byte;
            if (!next_valid && rx_backlog.size() != 0 &&
                $urandom_range(99) >= send_idle_pct)
            begin
                next_valid = 1'b1;
                next_byte = rx_backlog.pop_front();
            end
            rx_ch.valid <= next_valid;
            rx_ch.rx_byte <= next_byte;
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send(input logic [7:0] b);
        rx_backlog.push_back(b);
        bytes_queued++;
    endtask

    // One random piece of stream; mostly well-formed, some stray commands and raw noise.
    task automatic add_fragment();
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(19);
        if (pick < 7)
        begin
            send(8'($urandom_range(254)));
        end
        else if (pick < 9)
        begin
            send(BYTE_IAC);
            send(BYTE_IAC);
        end
        else if (pick < 11)
        begin
            send(BYTE_IAC);
            send(BYTE_EOR);
        end
        else if (pick < 15)
        begin
            send(BYTE_IAC);
            send(verb_bytes[$urandom_range(3)]);
            if ($urandom_range(1))
                send(known_opts[$urandom_range(3)]);
            else
                send(8'($urandom_range(255)));
        end
        else if (pick < 18)
        begin
            send(BYTE_IAC);
            send(BYTE_SB);
            n = $urandom_range(4);
            repeat (n)
            begin
                case ($urandom_range(5))
                    0:
                    begin
                        send(BYTE_IAC);
                        send(BYTE_IAC);
                    end
                    1:
                    begin
                        // An escape that is neither a doubled IAC nor SE is dropped.
                        b = 8'($urandom_range(254));
                        if (b == BYTE_SE)
                            b = 8'd241;
                        send(BYTE_IAC);
                        send(b);
                    end
                    default:
                        send(8'($urandom_range(254)));
                endcase
            end
            send(BYTE_IAC);
            send(BYTE_SE);
        end
        else if (pick == 18)
        begin
            send(BYTE_IAC);
            send(8'($urandom_range(255)));
        end
        else
        begin
            send(8'($urandom_range(255)));
        end
    endtask

    task automatic drain();
        while (bytes_taken != bytes_queued || due_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int target;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // EOR with nothing open, doubled IAC, EOR closing a record.
        send(BYTE_IAC); send(BYTE_EOR);
        send(BYTE_IAC); send(BYTE_IAC);
        send(BYTE_IAC); send(BYTE_EOR);
        // Negotiation: supported DO, unsupported WILL, then refusals that get no reply.
        send(BYTE_IAC); send(BYTE_DO);   send(OPT_TERMTYPE);
        send(BYTE_IAC); send(BYTE_WILL); send(8'd200);
        send(BYTE_IAC); send(BYTE_DONT); send(8'd0);
        send(BYTE_IAC); send(BYTE_WONT); send(OPT_NEWENV);
        // Unknown command, then an empty subnegotiation.
        send(BYTE_IAC); send(8'd241);
        send(BYTE_IAC); send(BYTE_SB); send(BYTE_IAC); send(BYTE_SE);

        for (int p = 0; p < 4; p++)
        begin
            // Every phase starts with the sender held back until all results are in.
            drain();
            send_idle_pct = phase_send_idle[p];
            recv_stall_pct = phase_recv_stall[p];
            target = bytes_queued + 65;
            while (bytes_queued < target)
                add_fragment();
        end
        drain();
        repeat (10) @(posedge clk);

        if (mismatches == 0 && due_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/tnrd_pkg.sv
rtl/tnrd_in_if.sv
rtl/tnrd_out_if.sv
rtl/tnrd_parser.sv
rtl/tnrd_out_buf.sv
rtl/telnet_receive_deframer.sv
rtl/tnrd_checker.sv
sim/telnet_receive_deframer_tb.sv
